// File: sv/sdtw_pkg.sv
// Shared types and constants of the length-normalized subsequence DTW block.
package sdtw_pkg;
   localparam int MaxRows = 1024;
   localparam int MaxCols = 1024;
   localparam int DistW = 16;
   localparam int CostW = 27;
   localparam int LenW = 11;
   localparam int DimW = 11;
   localparam int ScoreW = 16;
   localparam int CsrIdxW = 1;
   localparam logic [CsrIdxW-1:0] CsrNumRows = 1'b0;
   localparam logic [CsrIdxW-1:0] CsrNumCols = 1'b1;

   typedef struct packed {
      logic [CostW-1:0] cost;
      logic [LenW-1:0] len;
      logic [DimW-1:0] start;
   } cell_type;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_READ = 5'b00010,
      ST_MULT = 5'b00100,
      ST_PICK = 5'b01000,
      ST_DIV  = 5'b10000
   } state_type;
endpackage

// File: sv/sdtw_divider.sv
// Iterative restoring divider for the final score, one quotient bit per cycle.
module sdtw_divider (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  logic [sdtw_pkg::CostW-1:0] dividend,
   input  logic [sdtw_pkg::LenW-1:0] divisor,
   output logic busy,
   output logic [sdtw_pkg::ScoreW-1:0] quotient
);
   import sdtw_pkg::*;
   localparam int CntW = $clog2(CostW + 1);
   logic [CostW-1:0] quo_ff, quo_in;
   logic [LenW:0] rem_ff, rem_in;
   logic [LenW-1:0] dvs_ff, dvs_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in;
   logic [LenW:0] trial;

   always_comb begin
      quo_in = quo_ff;
      rem_in = rem_ff;
      dvs_in = dvs_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      trial = {rem_ff[LenW-1:0], quo_ff[CostW-1]};
      if (start) begin
         quo_in = dividend;
         rem_in = '0;
         dvs_in = (divisor == '0) ? LenW'(1) : divisor;
         cnt_in = CntW'(CostW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = trial - {1'b0, dvs_ff};
            quo_in = {quo_ff[CostW-2:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[CostW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CntW'(1);
         if (cnt_ff == CntW'(1)) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
      if (reset) busy_ff <= 1'b0;
      else busy_ff <= busy_in;
   end

   assign busy = busy_ff;
   assign quotient = quo_ff[ScoreW-1:0];
endmodule

// File: sv/sdtw_column_mem.sv
// Column store of cost, length and start with a registered read.
module sdtw_column_mem #(
   parameter int Depth = 1024
) (
   input  logic clock,
   input  logic wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  sdtw_pkg::cell_type wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output sdtw_pkg::cell_type rd_data
);
   import sdtw_pkg::*;
   cell_type mem [Depth];
   cell_type rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_ff <= mem[rd_addr];
   end

   assign rd_data = rd_ff;
endmodule

// File: sv/subsequence_dtw_length_normalized.sv
// Top level of the length-normalized subsequence DTW block.
//   channel | direction | handshake
//   req_    | in        | req_valid / req_ready
//   rsp_    | out       | rsp_valid / rsp_ready
//   csr_    | in        | csr_write, no wait
// A cell steps through request, column memory read, cross multiplies, pick and write back.
// The response valid is registered as the pick state ends, after the read and multiply states.
// The last cell of a grid also waits in ST_DIV for the bit-serial score divider.
// The result register holds while rsp_ready is low; the next request waits in its pick cycle.
// Reset is synchronous; the column store needs no clearing.
module subsequence_dtw_length_normalized (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic [sdtw_pkg::DistW-1:0] req_local_distance,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic [sdtw_pkg::CostW-1:0] rsp_cell_cost,
   output logic [sdtw_pkg::LenW-1:0] rsp_cell_length,
   output logic [sdtw_pkg::DimW-1:0] rsp_cell_start,
   output logic rsp_done_res,
   output logic [sdtw_pkg::ScoreW-1:0] rsp_score,
   output logic [sdtw_pkg::DimW-1:0] rsp_end_row,
   input  logic csr_write,
   input  logic [sdtw_pkg::CsrIdxW-1:0] csr_index,
   input  logic [sdtw_pkg::DimW-1:0] csr_data
);
   import sdtw_pkg::*;
   localparam int RowW = $clog2(MaxRows);
   localparam int ColW = $clog2(MaxCols);
   localparam int RcW = $clog2(MaxRows + 1);
   localparam int CcW = $clog2(MaxCols + 1);
   localparam int ProdW = CostW + LenW + 1;

   state_type st_ff, st_in;
   logic [DimW-1:0] nrows_ff, ncols_ff;
   logic [RowW-1:0] row_ff, row_in;
   logic [ColW-1:0] col_ff, col_in;
   cell_type above_ff, above_in, diag_ff, diag_in, best_ff, best_in;
   logic [DimW-1:0] brow_ff, brow_in;
   logic [CostW-1:0] d_ff;
   logic [ProdW-1:0] p_ld_ff, p_dl_ff, p_la_ff, p_al_ff, p_da_ff, p_ad_ff;
   cell_type cur_ff, cur_in;
   logic rv_ff, rv_in, last_ff, last_in;
   logic [DimW-1:0] endrow_ff, endrow_in;
   cell_type left;
   logic [RcW-1:0] rows;
   logic [CcW-1:0] cols;
   logic [RowW-1:0] r;
   logic [ColW-1:0] c;
   logic [CostW-1:0] lc, dc, ac;
   logic div_start, div_busy;
   logic [ScoreW-1:0] div_q;
   logic wr_en;
   cell_type pick;
   logic lastrow, lastcol;

   always_comb begin
      if (nrows_ff == '0) rows = RcW'(1);
      else if (32'(nrows_ff) > MaxRows) rows = RcW'(MaxRows);
      else rows = RcW'(nrows_ff);
      if (ncols_ff == '0) cols = CcW'(1);
      else if (32'(ncols_ff) > MaxCols) cols = CcW'(MaxCols);
      else cols = CcW'(ncols_ff);
      r = (RcW'(row_ff) >= rows) ? '0 : row_ff;
      c = (CcW'(col_ff) >= cols) ? '0 : col_ff;
      lastrow = (RcW'(r) == rows - RcW'(1));
      lastcol = (CcW'(c) == cols - CcW'(1));
   end

   sdtw_column_mem #(.Depth(MaxRows)) u_mem (
      .clock(clock), .wr_en(wr_en), .wr_addr(r), .wr_data(cur_in),
      .rd_addr(r), .rd_data(left)
   );

   sdtw_divider u_div (
      .clock(clock), .reset(reset), .start(div_start), .dividend(best_in.cost),
      .divisor(best_in.len), .busy(div_busy), .quotient(div_q)
   );

   assign lc = left.cost + d_ff;
   assign dc = diag_ff.cost + d_ff;
   assign ac = above_ff.cost + d_ff;
   assign req_ready = (st_ff == ST_IDLE);

   always_comb begin
      st_in = st_ff;
      row_in = row_ff;
      col_in = col_ff;
      above_in = above_ff;
      diag_in = diag_ff;
      best_in = best_ff;
      brow_in = brow_ff;
      cur_in = cur_ff;
      rv_in = rv_ff;
      last_in = last_ff;
      endrow_in = endrow_ff;
      wr_en = 1'b0;
      div_start = 1'b0;
      pick = left;
      if (rv_ff && rsp_ready) rv_in = 1'b0;
      unique case (st_ff)
         ST_IDLE: begin
            if (req_valid && req_ready) st_in = ST_READ;
         end
         ST_READ: st_in = ST_MULT;
         ST_MULT: st_in = ST_PICK;
         ST_PICK: begin
            if (!rv_ff || rsp_ready) begin
               if (c == '0) begin
                  cur_in = '{cost: d_ff, len: LenW'(1), start: DimW'(r) + DimW'(1)};
               end else begin
                  if (r == '0) pick = left;
                  else if (p_ld_ff <= p_dl_ff && p_la_ff <= p_al_ff) pick = left;
                  else if (p_da_ff <= p_ad_ff && p_dl_ff <= p_ld_ff) pick = diag_ff;
                  else pick = above_ff;
                  cur_in = '{cost: pick.cost + d_ff, len: pick.len + LenW'(1),
                             start: (r == '0) ? DimW'(1) : pick.start};
               end
               wr_en = 1'b1;
               diag_in = left;
               above_in = cur_in;
               if (lastcol && (r == '0 || cur_in.cost < best_ff.cost)) begin
                  best_in = cur_in;
                  brow_in = DimW'(r) + DimW'(1);
               end
               last_in = lastrow && lastcol;
               if (lastrow) begin
                  row_in = '0;
                  col_in = lastcol ? '0 : c + ColW'(1);
               end else begin
                  row_in = r + RowW'(1);
                  col_in = c;
               end
               if (lastrow && lastcol) begin
                  st_in = ST_DIV;
                  endrow_in = brow_in;
                  div_start = 1'b1;
               end else begin
                  rv_in = 1'b1;
                  st_in = ST_IDLE;
               end
            end
         end
         ST_DIV: begin
            if (!div_busy) begin
               rv_in = 1'b1;
               st_in = ST_IDLE;
            end
         end
         default: st_in = ST_IDLE;
      endcase
      if (csr_write) begin
         row_in = '0;
         col_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (st_ff == ST_IDLE && req_valid && req_ready) d_ff <= CostW'(req_local_distance);
      if (st_ff == ST_MULT) begin
         p_ld_ff <= ProdW'(lc) * ProdW'({1'b0, diag_ff.len} + 12'd1);
         p_dl_ff <= ProdW'(dc) * ProdW'({1'b0, left.len} + 12'd1);
         p_la_ff <= ProdW'(lc) * ProdW'({1'b0, above_ff.len} + 12'd1);
         p_al_ff <= ProdW'(ac) * ProdW'({1'b0, left.len} + 12'd1);
         p_da_ff <= ProdW'(dc) * ProdW'({1'b0, above_ff.len} + 12'd1);
         p_ad_ff <= ProdW'(ac) * ProdW'({1'b0, diag_ff.len} + 12'd1);
      end
      cur_ff <= cur_in;
      endrow_ff <= endrow_in;
      last_ff <= last_in;
      if (reset) begin
         st_ff <= ST_IDLE;
         nrows_ff <= DimW'(1024);
         ncols_ff <= DimW'(1024);
         row_ff <= '0;
         col_ff <= '0;
         above_ff <= '0;
         diag_ff <= '0;
         best_ff <= '0;
         brow_ff <= '0;
         rv_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         above_ff <= above_in;
         diag_ff <= diag_in;
         best_ff <= best_in;
         brow_ff <= brow_in;
         rv_ff <= rv_in;
         row_ff <= row_in;
         col_ff <= col_in;
         if (csr_write) begin
            if (csr_index == CsrNumRows) nrows_ff <= csr_data;
            else ncols_ff <= csr_data;
         end
      end
   end

   assign rsp_valid = rv_ff;
   assign rsp_cell_cost = cur_ff.cost;
   assign rsp_cell_length = cur_ff.len;
   assign rsp_cell_start = cur_ff.start;
   assign rsp_done_res = last_ff;
   assign rsp_score = last_ff ? div_q : '0;
   assign rsp_end_row = last_ff ? endrow_ff : '0;
endmodule

// File: sv/sdtw_checker.sv
// Port-level checker for the DTW block and its bind.
module sdtw_checker (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   input  logic req_ready,
   input  logic rsp_valid,
   input  logic rsp_ready,
   input  logic rsp_done_res,
   input  logic [sdtw_pkg::CostW-1:0] rsp_cell_cost,
   input  logic [sdtw_pkg::LenW-1:0] rsp_cell_length,
   input  logic [sdtw_pkg::DimW-1:0] rsp_end_row
);
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready) else $error("request taken while busy");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_cell_cost))
      else $error("response changed under stall");
   a_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_cell_length != '0) else $error("zero path length");
   a_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_done_res |-> rsp_end_row == '0) else $error("end row off last cell");
endmodule

bind subsequence_dtw_length_normalized sdtw_checker u_sdtw_checker (.*);
